// ----- rtl/dssu_pkg.sv -----
package dssu_pkg;

  localparam int TOP_DIGITS    = 6;
  localparam int BOTTOM_DIGITS = 4;
  localparam int STORE_DEPTH   = TOP_DIGITS + BOTTOM_DIGITS;

  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int TOP_IDX_W = (TOP_DIGITS > 1) ? $clog2(TOP_DIGITS) : 1;
  localparam int BOT_IDX_W = (BOTTOM_DIGITS > 1) ? $clog2(BOTTOM_DIGITS) : 1;

  localparam int TOP_POS_W = 3;
  localparam int BOT_POS_W = 2;
  localparam int PATTERN_W = 8;
  localparam int DIGIT_W   = 4;
  localparam int SLOT_W    = 4;

  localparam logic [BOT_POS_W-1:0] POINT_FIRST   = 2'd2;
  localparam logic [BOT_POS_W-1:0] POINT_LAST    = 2'd3;
  localparam logic [PATTERN_W-1:0] POINT_PATTERN = 8'h01;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  // Store read addresses for the next tick
  typedef struct packed {
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] bot_addr;
  } rd_req_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] top_pattern;
    logic [TOP_POS_W-1:0] top_position;
    logic                 top_lit;
    logic [PATTERN_W-1:0] bottom_pattern;
    logic [BOT_POS_W-1:0] bottom_position;
    logic                 bottom_lit;
  } scan_res_t;

  function automatic logic [PATTERN_W-1:0] top_decode(input logic [DIGIT_W-1:0] d);
    logic [PATTERN_W-1:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Bit-reversed segment order of the top table
  function automatic logic [PATTERN_W-1:0] bottom_decode(input logic [DIGIT_W-1:0] d);
    logic [PATTERN_W-1:0] p;
    unique case (d)
      4'd0:    p = 8'hFC;
      4'd1:    p = 8'h60;
      4'd2:    p = 8'hDA;
      4'd3:    p = 8'hF2;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'hB6;
      4'd6:    p = 8'hBE;
      4'd7:    p = 8'hE0;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hF6;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/dssu_store.sv -----
module dssu_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [dssu_pkg::SLOT_W-1:0]   wr_slot,
  input  logic [dssu_pkg::DIGIT_W-1:0]  wr_value,
  input  dssu_pkg::rd_req_t             rd_req,
  output logic [dssu_pkg::DIGIT_W-1:0]  top_digit,
  output logic [dssu_pkg::DIGIT_W-1:0]  bot_digit
);
  import dssu_pkg::*;

  logic [DIGIT_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic                   in_range;
  logic                   wr_go;
  logic [ADDR_W-1:0]      wr_addr;

  assign in_range = ({1'b0, wr_slot} < (SLOT_W + 1)'(STORE_DEPTH));
  assign wr_go    = wr_en && in_range;
  assign wr_addr  = wr_slot[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= wr_value;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_go) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered reads with write bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      top_digit <= '0;
      bot_digit <= '0;
    end else begin
      if (wr_go && wr_addr == rd_req.top_addr) begin
        top_digit <= wr_value;
      end else if (valid[rd_req.top_addr]) begin
        top_digit <= mem[rd_req.top_addr];
      end else begin
        top_digit <= '0;
      end
      if (wr_go && wr_addr == rd_req.bot_addr) begin
        bot_digit <= wr_value;
      end else if (valid[rd_req.bot_addr]) begin
        bot_digit <= mem[rd_req.bot_addr];
      end else begin
        bot_digit <= '0;
      end
    end
  end

endmodule

// ----- rtl/dssu_scan.sv -----
module dssu_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic [dssu_pkg::DIGIT_W-1:0]  top_digit,
  input  logic [dssu_pkg::DIGIT_W-1:0]  bot_digit,
  output dssu_pkg::rd_req_t             rd_req,
  output dssu_pkg::scan_res_t           res
);
  import dssu_pkg::*;

  logic                 top_on_phase, top_on_phase_next;
  logic [TOP_IDX_W-1:0] top_index, top_index_next;
  logic                 bottom_on_phase, bottom_on_phase_next;
  logic [BOT_IDX_W-1:0] bottom_index, bottom_index_next;
  logic                 point_mode, point_mode_next;
  logic                 point_on_phase, point_on_phase_next;
  logic [BOT_POS_W-1:0] point_index, point_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_on_phase    <= 1'b1;
      top_index       <= '0;
      bottom_on_phase <= 1'b1;
      bottom_index    <= '0;
      point_mode      <= 1'b0;
      point_on_phase  <= 1'b1;
      point_index     <= POINT_FIRST;
    end else begin
      top_on_phase    <= top_on_phase_next;
      top_index       <= top_index_next;
      bottom_on_phase <= bottom_on_phase_next;
      bottom_index    <= bottom_index_next;
      point_mode      <= point_mode_next;
      point_on_phase  <= point_on_phase_next;
      point_index     <= point_index_next;
    end
  end

  always_comb begin
    top_on_phase_next    = top_on_phase;
    top_index_next       = top_index;
    bottom_on_phase_next = bottom_on_phase;
    bottom_index_next    = bottom_index;
    point_mode_next      = point_mode;
    point_on_phase_next  = point_on_phase;
    point_index_next     = point_index;

    res.top_position = TOP_POS_W'(top_index);
    res.top_lit      = top_on_phase;
    res.top_pattern  = top_on_phase ? top_decode(top_digit) : '0;

    if (!point_mode) begin
      res.bottom_position = BOT_POS_W'(bottom_index);
      res.bottom_lit      = bottom_on_phase;
      res.bottom_pattern  = bottom_on_phase ? bottom_decode(bot_digit) : '0;
    end else begin
      res.bottom_position = point_index;
      res.bottom_lit      = point_on_phase;
      res.bottom_pattern  = point_on_phase ? POINT_PATTERN : '0;
    end

    if (tick) begin
      top_on_phase_next = !top_on_phase;
      if (!top_on_phase) begin
        top_index_next = (top_index == TOP_IDX_W'(TOP_DIGITS - 1)) ? '0 : top_index + 1'b1;
      end
      if (!point_mode) begin
        bottom_on_phase_next = !bottom_on_phase;
        if (!bottom_on_phase) begin
          if (bottom_index == BOT_IDX_W'(BOTTOM_DIGITS - 1)) begin
            bottom_index_next = '0;
            point_mode_next   = 1'b1;
          end else begin
            bottom_index_next = bottom_index + 1'b1;
          end
        end
      end else begin
        point_on_phase_next = !point_on_phase;
        if (!point_on_phase) begin
          if (point_index == POINT_LAST) begin
            point_index_next = POINT_FIRST;
            point_mode_next  = 1'b0;
          end else begin
            point_index_next = point_index + 1'b1;
          end
        end
      end
    end
  end

  // Fetch the digits the next tick will show
  assign rd_req.top_addr = ADDR_W'(top_index_next);
  assign rd_req.bot_addr = ADDR_W'(TOP_DIGITS) + ADDR_W'(bottom_index_next);

endmodule

// ----- rtl/dual_seven_segment_scanner_unit.sv -----
// A tick transfer's result is registered and shows on m_tdata in the cycle after acceptance.
// One item per cycle unless a held result waits on m_tready; the output register
// refills in the cycle it drains. Digit writes produce no result.
// Reset (rst, synchronous, active high): all stored digits read as zero,
// both scanners restart lit at digit 0, the point pass restarts at digit 2.
module dual_seven_segment_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] digit_slot, [7:4] digit_value
  input  logic        s_tuser,   // [0] func (0 tick, 1 digit write)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] top_pattern, [10:8] top_position,
                                 // [11] top_lit, [19:12] bottom_pattern,
                                 // [21:20] bottom_position, [22] bottom_lit,
                                 // [23] zero
);
  import dssu_pkg::*;

  logic               accept;
  logic               tick;
  logic               wr_en;
  logic [DIGIT_W-1:0] top_digit;
  logic [DIGIT_W-1:0] bot_digit;
  rd_req_t            rd_req;
  scan_res_t          res;
  scan_res_t          out_res;

  // Take a new item whenever the output register is empty or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign tick     = accept && (func_t'(s_tuser) == FUNC_TICK);
  assign wr_en    = accept && (func_t'(s_tuser) == FUNC_WRITE);

  // Digit store: ten entries, one write port, two registered read ports
  dssu_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_slot   (s_tdata[3:0]),
    .wr_value  (s_tdata[7:4]),
    .rd_req    (rd_req),
    .top_digit (top_digit),
    .bot_digit (bot_digit)
  );

  // Both scanners; advance only on an accepted tick
  dssu_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .top_digit (top_digit),
    .bot_digit (bot_digit),
    .rd_req    (rd_req),
    .res       (res)
  );

  // Output register: load on tick, drop valid once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.bottom_lit, out_res.bottom_position, out_res.bottom_pattern,
                    out_res.top_lit, out_res.top_position, out_res.top_pattern};

  // A blank top phase never carries segments
  a_top_blank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[11] |-> m_tdata[7:0] == 8'h00)
    else $error("top pattern nonzero in blank phase");

  // A digit write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !m_tvalid)
    else $error("result appeared after a digit write");

  // Every tick produces a result
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> m_tvalid)
    else $error("tick produced no result");

  // Top position stays within the digit count
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:8] < TOP_POS_W'(TOP_DIGITS))
    else $error("top position out of range");

  // Top scanner alternates lit and blank on the results of back-to-back ticks
  a_top_alt: assert property (@(posedge clk) disable iff (rst)
    tick && $past(tick) && !$past(rst) |=> m_tdata[11] != $past(m_tdata[11]))
    else $error("top phase did not alternate");

endmodule
